[sv/cpf_pkg.sv]
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types, item codes and the CRC-8 (poly 0x07) byte fold for the
// packet framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [2:0]  mode_t;
  typedef logic [15:0] half_t;
  typedef logic [31:0] word_t;

  // Item codes carried on the mode field
  localparam mode_t MODE_START  = 3'd0;
  localparam mode_t MODE_BYTE   = 3'd1;
  localparam mode_t MODE_WORD16 = 3'd2;
  localparam mode_t MODE_WORD32 = 3'd3;
  localparam mode_t MODE_FINISH = 3'd4;

  // Configuration register indexes
  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  // Longest run of bytes one item can cause (start item)
  localparam int unsigned MAX_BYTES = 7;
  localparam int unsigned IDX_W     = $clog2(MAX_BYTES);

  typedef logic [IDX_W-1:0] idx_t;

  localparam byte_t CRC_POLY   = 8'h07;
  localparam byte_t CRC_TOPBIT = 8'h80;

  // Fold one byte into a CRC-8, MSB first
  function automatic byte_t crc8_fold(input byte_t acc, input byte_t b);
    byte_t c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[sv/cpf_if.sv]
// ----------------------------------------------------------------------------
// cpf_cmd_if / cpf_tx_if
// Valid/ready channels of the packet framer: command items in, bytes out.
// ----------------------------------------------------------------------------
interface cpf_cmd_if;
  logic          valid;
  logic          ready;
  cpf_pkg::mode_t mode;
  cpf_pkg::word_t value;
  cpf_pkg::byte_t packet_type;
  cpf_pkg::half_t frame_num;
  cpf_pkg::half_t packet_length;

  modport source (output valid, mode, value, packet_type, frame_num, packet_length,
                  input ready);
  modport sink   (input valid, mode, value, packet_type, frame_num, packet_length,
                  output ready);
endinterface

interface cpf_tx_if;
  logic           valid;
  logic           ready;
  cpf_pkg::byte_t tx_byte;
  logic           last_of_run;

  modport source (output valid, tx_byte, last_of_run, input ready);
  modport sink   (input valid, tx_byte, last_of_run, output ready);
endinterface

[sv/crc8_packet_framer.sv]
// ----------------------------------------------------------------------------
// crc8_packet_framer
// Turns command items into a little-endian byte stream with sync bytes,
// header and a CRC-8 (poly 0x07, MSB first, init 0) trailer.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake        Payload
//  cmd      in   valid/ready      mode, value, packet_type, frame_num,
//                                 packet_length
//  tx       out  valid/ready      tx_byte, last_of_run
//  cfg      in   cfg_we only      cfg_index (0 sync_first, 1 sync_second),
//                                 cfg_data
//
//  Rate: one byte leaves per cycle unless tx stalls, and an item causes as
//  many bytes as follows: start 7, byte 1, word16 2, word32 4, finish 1.
//  The single byte port of the output register sets that rate.
//  An item with an undefined mode is taken and dropped: it sends no byte but
//  leaves the serializer empty.
//  Reset (synchronous, rst high) empties both stages and clears the CRC and
//  the sync registers. A stall on tx holds the output register and the
//  serializer; the next item is taken in the cycle its predecessor's last
//  byte moves into the output register.
//
module crc8_packet_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  cpf_pkg::byte_t       cfg_data,
  cpf_cmd_if.sink              cmd,
  cpf_tx_if.source             tx
);

  // Configuration registers
  cpf_pkg::byte_t sync_first;
  cpf_pkg::byte_t sync_second;

  // Serializer stage: one decoded item, its bytes in send order
  logic                              hold_valid;
  cpf_pkg::byte_t [cpf_pkg::MAX_BYTES-1:0] hold_bytes;
  logic [cpf_pkg::MAX_BYTES-1:0]     hold_fold;     // byte folds into CRC
  cpf_pkg::idx_t                     hold_last;     // index of final byte
  logic                              hold_start;    // CRC restarts at type byte
  logic                              hold_finish;   // byte is the CRC itself
  cpf_pkg::idx_t                     idx;

  cpf_pkg::byte_t running_crc;

  // Decoded view of the incoming item
  cpf_pkg::byte_t [cpf_pkg::MAX_BYTES-1:0] dec_bytes;
  logic [cpf_pkg::MAX_BYTES-1:0]     dec_fold;
  cpf_pkg::idx_t                     dec_last;
  logic                              dec_ok;
  logic                              dec_start;
  logic                              dec_finish;

  logic           emit_fire;
  logic           emit_last;
  cpf_pkg::byte_t emit_byte;
  cpf_pkg::byte_t crc_base;
  logic           take;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= '0;
      sync_second <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cpf_pkg::CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        cpf_pkg::CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode: lay the item out as bytes in wire order
  always_comb begin
    dec_bytes  = '0;
    dec_fold   = '0;
    dec_last   = '0;
    dec_ok     = 1'b1;
    dec_start  = 1'b0;
    dec_finish = 1'b0;
    case (cmd.mode)
      cpf_pkg::MODE_START: begin
        dec_bytes[0] = sync_first;
        dec_bytes[1] = sync_second;
        dec_bytes[2] = cmd.packet_type;
        dec_bytes[3] = cmd.frame_num[7:0];
        dec_bytes[4] = cmd.frame_num[15:8];
        dec_bytes[5] = cmd.packet_length[7:0];
        dec_bytes[6] = cmd.packet_length[15:8];
        dec_fold     = 7'b111_1100;   // sync bytes stay outside the CRC
        dec_last     = cpf_pkg::idx_t'(cpf_pkg::MAX_BYTES - 1);
        dec_start    = 1'b1;
      end
      cpf_pkg::MODE_BYTE: begin
        dec_bytes[0] = cmd.value[7:0];
        dec_fold     = 7'b000_0001;
        dec_last     = cpf_pkg::idx_t'(0);
      end
      cpf_pkg::MODE_WORD16: begin
        dec_bytes[0] = cmd.value[7:0];
        dec_bytes[1] = cmd.value[15:8];
        dec_fold     = 7'b000_0011;
        dec_last     = cpf_pkg::idx_t'(1);
      end
      cpf_pkg::MODE_WORD32: begin
        dec_bytes[0] = cmd.value[7:0];
        dec_bytes[1] = cmd.value[15:8];
        dec_bytes[2] = cmd.value[23:16];
        dec_bytes[3] = cmd.value[31:24];
        dec_fold     = 7'b000_1111;
        dec_last     = cpf_pkg::idx_t'(3);
      end
      cpf_pkg::MODE_FINISH: begin
        dec_last     = cpf_pkg::idx_t'(0);
        dec_finish   = 1'b1;          // trailer is read from the CRC at send
      end
      default: begin
        dec_ok = 1'b0;                // drop undefined modes
      end
    endcase
  end

  // Advance one byte whenever the output register is free or being drained
  assign emit_fire = hold_valid && (!tx.valid || tx.ready);
  assign emit_last = (idx == hold_last);
  assign cmd.ready = !hold_valid || (emit_fire && emit_last);
  assign take      = cmd.valid && cmd.ready;

  assign emit_byte = hold_finish ? running_crc : hold_bytes[idx];
  // Restart the CRC at the type byte of a start item
  assign crc_base  = (hold_start && idx == cpf_pkg::idx_t'(2)) ? 8'h00 : running_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (take) begin
        hold_valid <= dec_ok;
        idx        <= '0;
      end else if (emit_fire) begin
        if (emit_last) begin
          hold_valid <= 1'b0;
        end else begin
          idx <= idx + cpf_pkg::idx_t'(1);
        end
      end
    end
  end

  // Item payload: no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      hold_bytes  <= dec_bytes;
      hold_fold   <= dec_fold;
      hold_last   <= dec_last;
      hold_start  <= dec_start;
      hold_finish <= dec_finish;
    end
  end

  // Running CRC: fold each sent byte that belongs to the checked region
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
    end else if (emit_fire && hold_fold[idx]) begin
      running_crc <= cpf_pkg::crc8_fold(crc_base, emit_byte);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (emit_fire) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      tx.tx_byte     <= emit_byte;
      tx.last_of_run <= emit_last;
    end
  end

endmodule
